@@ design/s4kvs_pkg.sv @@
// ----------------------------------------------------------------------------
// s4kvs_pkg - shared definitions for the sparse 4D key/value store
// Sizes, request codes, sequencer states and the bucket hash.
// ----------------------------------------------------------------------------
package s4kvs_pkg;

  // Table geometry; CAPACITY must be a power of two
  localparam int CAPACITY   = 256;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int PROBE_W    = IDX_W + 1;
  localparam int COORD_BITS = 16;
  localparam int KEY_W      = 4 * COORD_BITS;
  localparam int VAL_W      = 32;
  localparam int ENTRY_W    = KEY_W + VAL_W;
  localparam int COUNT_W    = 9;
  localparam int HASH_CHUNKS = KEY_W / IDX_W;

  // Request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_ERASE  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  // Status codes
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  // Home bucket: XOR fold of the packed key
  function automatic logic [IDX_W-1:0] bucket_hash(input logic [KEY_W-1:0] key);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < HASH_CHUNKS; i++) begin
      h = h ^ key[i*IDX_W +: IDX_W];
    end
    return h;
  endfunction

endpackage

@@ design/sparse_4d_key_value_store_core.sv @@
// ----------------------------------------------------------------------------
// sparse_4d_key_value_store_core - sparse store keyed by four coordinates
// Open-addressed hash table with linear probing over one entry memory.
// ----------------------------------------------------------------------------
// Requests are taken when start is high and busy is low; every request
// gives exactly one result word, shown for one cycle with strobe_o high,
// and the receiver cannot stall it. Clear, and an insert of the default
// value, answer in the cycle after acceptance. Other requests walk a probe
// sequence from the home bucket: each occupied slot is read from the
// single-port entry memory and then its key is compared, each erased slot
// is stepped over, and an insert ends with a write of the entry memory.
// The worst case is a sweep of the whole table. Slot state is held in
// flip-flops, so clear resets every slot at once and no clearing pass
// follows reset.
module sparse_4d_key_value_store_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 default_value_we_i,
  input  logic signed [s4kvs_pkg::VAL_W-1:0]   default_value_i,
  // request
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [1:0]                    req_type_i,
  input  logic signed [15:0]                   key_first_i,
  input  logic signed [15:0]                   key_second_i,
  input  logic signed [15:0]                   key_third_i,
  input  logic signed [15:0]                   key_fourth_i,
  input  logic signed [s4kvs_pkg::VAL_W-1:0]   write_value_i,
  // result
  output logic                                 strobe_o,
  output logic signed [s4kvs_pkg::VAL_W-1:0]   read_value_o,
  output logic        [s4kvs_pkg::COUNT_W-1:0] entry_count_o,
  output logic                                 status_o
);
  import s4kvs_pkg::*;

  state_e               state_q, state_d;
  req_e                 op_q, req_in;
  logic [KEY_W-1:0]     key_q, key_in;
  logic [VAL_W-1:0]     wval_q, dflt_q;
  logic [IDX_W-1:0]     probe_q, probe_nxt, free_q, wr_addr_q, ins_slot;
  logic [PROBE_W-1:0]   cnt_q;
  logic                 free_vld_q;
  logic [CAPACITY-1:0]  valid_q, used_q;
  logic [COUNT_W-1:0]   occ_q;
  logic [ENTRY_W-1:0]   mem [CAPACITY];
  logic [ENTRY_W-1:0]   rd_q;
  logic                 strobe_q, status_q;
  logic [VAL_W-1:0]     rval_q;

  logic accept, quick, exhausted, miss, tomb, rd_en, hit, advance;
  logic have_slot, new_ins, fin_miss, fin_hit, fin_write, erase_hit;

  // Request decode
  assign req_in = req_e'(req_type_i);
  assign key_in = {key_fourth_i[COORD_BITS-1:0], key_third_i[COORD_BITS-1:0],
                   key_second_i[COORD_BITS-1:0], key_first_i[COORD_BITS-1:0]};
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign quick  = (req_in == REQ_CLEAR) ||
                  ((req_in == REQ_INSERT) && (write_value_i == dflt_q));

  // Probe step decode
  assign exhausted = (cnt_q == PROBE_W'(CAPACITY));
  assign miss      = (state_q == ST_PROBE) && (exhausted || !used_q[probe_q]);
  assign tomb      = (state_q == ST_PROBE) && !exhausted && used_q[probe_q] &&
                     !valid_q[probe_q];
  assign rd_en     = (state_q == ST_PROBE) && !exhausted && valid_q[probe_q];
  assign hit       = (state_q == ST_CMP) && (rd_q[ENTRY_W-1 -: KEY_W] == key_q);
  assign advance   = tomb || ((state_q == ST_CMP) && !hit);
  assign probe_nxt = (probe_q == IDX_W'(CAPACITY - 1)) ? '0 : probe_q + 1'b1;

  // Miss outcome: first erased slot seen, else the empty slot that ended it
  assign have_slot = free_vld_q || !exhausted;
  assign ins_slot  = free_vld_q ? free_q : probe_q;
  assign new_ins   = miss && (op_q == REQ_INSERT) && have_slot;
  assign fin_miss  = miss && !new_ins;
  assign fin_hit   = hit && (op_q != REQ_INSERT);
  assign erase_hit = hit && (op_q == REQ_ERASE);
  assign fin_write = (state_q == ST_WRITE);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !quick) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (miss) begin
          state_d = new_ins ? ST_WRITE : ST_IDLE;
        end else if (rd_en) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (hit) begin
          state_d = (op_q == REQ_INSERT) ? ST_WRITE : ST_IDLE;
        end else begin
          state_d = ST_PROBE;
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      dflt_q     <= '0;
      valid_q    <= '0;
      used_q     <= '0;
      occ_q      <= '0;
      strobe_q   <= 1'b0;
      free_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (accept && quick) || fin_miss || fin_hit || fin_write;
      if (default_value_we_i) dflt_q <= default_value_i;
      // probe bookkeeping
      if (accept) begin
        cnt_q      <= '0;
        free_vld_q <= 1'b0;
      end else if (advance) begin
        cnt_q <= cnt_q + 1'b1;
        if (tomb && !free_vld_q) free_vld_q <= 1'b1;
      end
      // slot state and entry count
      if (accept && (req_in == REQ_CLEAR)) begin
        valid_q <= '0;
        used_q  <= '0;
        occ_q   <= '0;
      end else if (new_ins) begin
        valid_q[ins_slot] <= 1'b1;
        used_q[ins_slot]  <= 1'b1;
        occ_q             <= occ_q + 1'b1;
      end else if (erase_hit) begin
        valid_q[probe_q] <= 1'b0;
        occ_q            <= occ_q - 1'b1;
      end
    end
  end

  // Request payload, probe pointer and result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= req_in;
      key_q   <= key_in;
      wval_q  <= write_value_i;
      probe_q <= bucket_hash(key_in);
    end else if (advance) begin
      probe_q <= probe_nxt;
    end
    if (tomb && !free_vld_q) free_q <= probe_q;
    if (new_ins) begin
      wr_addr_q <= ins_slot;
    end else if (hit) begin
      wr_addr_q <= probe_q;
    end
    rval_q   <= (fin_hit && (op_q == REQ_LOOKUP)) ? rd_q[VAL_W-1:0] : dflt_q;
    status_q <= (fin_miss && (op_q == REQ_INSERT)) ? STATUS_FULL : STATUS_DONE;
  end

  // Entry memory: one port, registered read
  always_ff @(posedge clk_i) begin
    if (fin_write) begin
      mem[wr_addr_q] <= {key_q, wval_q};
    end else if (rd_en) begin
      rd_q <= mem[probe_q];
    end
  end

  assign strobe_o      = strobe_q;
  assign read_value_o  = rval_q;
  assign entry_count_o = occ_q;
  assign status_o      = status_q;

`ifndef SYNTHESIS
  // every live slot is marked used
  a_valid_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q & ~used_q) == '0)
    else $error("live slot not marked used");

  // entry count tracks the live slots
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("entry count out of step with slot state");

  // clear answers next cycle with an empty table
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_in == REQ_CLEAR)) |=> (strobe_o && (entry_count_o == '0)))
    else $error("clear did not complete");

  // a result word coincides with the return to idle
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result shown while busy");
`endif

endmodule
